>>> rtl/sfm_pkg.sv
package sfm_pkg;

    // Default sizes of the pattern table
    localparam int NUM_PATTERNS_DEF = 8;
    localparam int MAX_PAT_LEN_DEF  = 16;

    // Field widths fixed by the item format
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int BIDX_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 5;
    localparam int POS_W   = 40;
    localparam int CFG_IDX_W = 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Item operations
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_BYTE = 2'd0,
        OP_LOAD_ATTR = 2'd1,
        OP_FILE_BYTE = 2'd2,
        OP_EOF       = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'b1;

    // Control from the top level to one slot
    typedef struct packed {
        logic              byte_we;
        logic              attr_we;
        logic              file_byte;
        logic              clr;
        logic [BIDX_W-1:0] idx;
        logic [BYTE_W-1:0] value;
        logic [PLEN_W-1:0] len;
        logic              len_ok;
        logic              anchored;
        logic [POS_W-1:0]  start;
        logic              negate;
        logic              enable;
    } t_slot_ctl;

    // Status of one slot
    typedef struct packed {
        logic enabled;
        logic negated;
        logic hit;
    } t_slot_stat;

endpackage

>>> rtl/sfm_in_if.sv
interface sfm_in_if import sfm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic [PLEN_W-1:0] pattern_length;
    logic              anchored;
    logic [POS_W-1:0]  anchor_offset;
    logic              negate;
    logic              enable;

    modport source (output valid, operation, slot, byte_index, byte_value, pattern_length,
                    anchored, anchor_offset, negate, enable, input ready);
    modport sink   (input valid, operation, slot, byte_index, byte_value, pattern_length,
                    anchored, anchor_offset, negate, enable, output ready);
endinterface

>>> rtl/sfm_out_if.sv
interface sfm_out_if import sfm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             size_ok;
    logic             include_hit;
    logic             exclude_hit;
    logic [POS_W-1:0] file_size;

    modport source (output valid, accepted, size_ok, include_hit, exclude_hit, file_size,
                    input ready);
    modport sink   (input valid, accepted, size_ok, include_hit, exclude_hit, file_size,
                    output ready);
endinterface

>>> rtl/sfm_cell.sv
module sfm_cell import sfm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_clr,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_byte
);
    logic [BYTE_W-1:0] r_byte;

    // One window stage: takes its neighbor's byte on each file byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
endmodule

>>> rtl/sfm_slot.sv
module sfm_slot import sfm_pkg::*; #(
    parameter int MAX_PAT_LEN = MAX_PAT_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_slot_ctl                          i_ctl,
    input  logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] i_win,
    input  logic [POS_W-1:0]                   i_pos,
    output t_slot_stat                         o_stat
);
    localparam int IW = (MAX_PAT_LEN > 1) ? $clog2(MAX_PAT_LEN) : 1;
    localparam int CW = 8;

    logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] r_pat;
    logic [PLEN_W-1:0]                  r_len;
    logic                               r_anchor;
    logic [POS_W:0]                     r_end;
    logic                               r_neg;
    logic                               r_en;
    logic                               r_hit;
    logic [MAX_PAT_LEN-1:0]             w_ok;
    logic                               w_body;
    logic                               w_far;
    logic                               w_at;
    logic                               w_hit;

    // Pattern bytes, attributes: no reset, loaded before use
    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_we) begin
            r_pat[i_ctl.idx[IW-1:0]] <= i_ctl.value;
        end
        if (i_ctl.attr_we) begin
            r_len    <= i_ctl.len;
            r_anchor <= i_ctl.anchored;
            r_neg    <= i_ctl.negate;
            // last byte offset of an anchored pattern
            r_end    <= {1'b0, i_ctl.start} + (POS_W+1)'(i_ctl.len) - (POS_W+1)'(1);
        end
    end

    // Window position k holds pattern byte len-1-k
    always_comb begin
        for (int k = 0; k < MAX_PAT_LEN; k++) begin
            logic [CW-1:0] v_pi;
            v_pi = CW'(r_len) - CW'(k) - CW'(1);
            w_ok[k] = (CW'(k) >= CW'(r_len)) || (r_pat[v_pi[IW-1:0]] == i_win[k]);
        end
    end

    assign w_body = &w_ok;
    assign w_far  = ({1'b0, i_pos} + (POS_W+1)'(1)) >= (POS_W+1)'(r_len);
    assign w_at   = !r_anchor || (r_end == {1'b0, i_pos});
    assign w_hit  = r_en && w_body && w_far && w_at;

    // Enable and sticky hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (i_ctl.attr_we) begin
                r_en <= i_ctl.len_ok && i_ctl.enable;
            end
            if (i_ctl.attr_we || i_ctl.clr) begin
                r_hit <= 1'b0;
            end else if (i_ctl.file_byte && w_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_stat.enabled = r_en;
    assign o_stat.negated = r_neg;
    assign o_stat.hit     = r_hit;
endmodule

>>> rtl/file_content_signature_filter_top.sv
// Channel  Dir  Payload
// i_in     in   operation, slot, byte_index, byte_value, pattern_length, anchored,
//               anchor_offset, negate, enable
// o_out    out  accepted, size_ok, include_hit, exclude_hit, file_size (end of file only)
//
// One item per cycle; every slot compares its pattern against the shifted
// window in the cycle the file byte is taken. A verdict shows in the cycle after the
// end-of-file item is taken, from the output register. Reset clears enables, hit
// flags, window, byte count and size bounds; pattern bytes and attributes keep no
// reset. Input is stalled only while a verdict waits and the output is not ready.
module file_content_signature_filter_top import sfm_pkg::*; #(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
    parameter int MAX_PAT_LEN  = MAX_PAT_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data,
    sfm_in_if.sink               i_in,
    sfm_out_if.source            o_out
);
    localparam int NW = 8;

    logic [POS_W-1:0]                   r_min;
    logic [POS_W-1:0]                   r_max;
    logic [POS_W-1:0]                   r_pos;
    logic                               r_ov;
    logic                               r_acc;
    logic                               r_sok;
    logic                               r_inc;
    logic                               r_exc;
    logic [POS_W-1:0]                   r_size;
    logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] w_win;
    logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] w_next;
    t_slot_stat [NUM_PATTERNS-1:0]      w_stat;
    logic                               w_take;
    logic                               w_byte;
    logic                               w_eof;
    logic                               w_sok;
    logic                               w_inc;
    logic                               w_exc;
    logic                               w_any;
    t_op                                w_op;

    assign w_op       = t_op'(i_in.operation);
    assign i_in.ready = !r_ov || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_byte     = w_take && (w_op == OP_FILE_BYTE);
    assign w_eof      = w_take && (w_op == OP_EOF);

    // Size bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= POS_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_SIZE: r_min <= i_cfg_data;
                CFG_MAX_SIZE: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window chain: cell 0 takes the new byte
    for (genvar k = 0; k < MAX_PAT_LEN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_next[k] = i_in.byte_value;
        end else begin : g_body
            assign w_next[k] = w_win[k-1];
        end
        sfm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_byte),
            .i_clr  (w_eof),
            .i_byte (w_next[k]),
            .o_byte (w_win[k])
        );
    end

    // Pattern slots
    for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_slot
        t_slot_ctl v_ctl;
        logic      v_sel;
        assign v_sel = (NW'(i_in.slot) == NW'(s));
        always_comb begin
            v_ctl.byte_we   = w_take && (w_op == OP_LOAD_BYTE) && v_sel
                              && (NW'(i_in.byte_index) < NW'(MAX_PAT_LEN));
            v_ctl.attr_we   = w_take && (w_op == OP_LOAD_ATTR) && v_sel;
            v_ctl.file_byte = w_byte;
            v_ctl.clr       = w_eof;
            v_ctl.idx       = i_in.byte_index;
            v_ctl.value     = i_in.byte_value;
            v_ctl.len       = i_in.pattern_length;
            v_ctl.len_ok    = (i_in.pattern_length != '0)
                              && (NW'(i_in.pattern_length) <= NW'(MAX_PAT_LEN));
            v_ctl.anchored  = i_in.anchored;
            v_ctl.start     = i_in.anchor_offset;
            v_ctl.negate    = i_in.negate;
            v_ctl.enable    = i_in.enable;
        end
        sfm_slot #(.MAX_PAT_LEN(MAX_PAT_LEN)) u_slot (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (v_ctl),
            .i_win  (w_next),
            .i_pos  (r_pos),
            .o_stat (w_stat[s])
        );
    end

    // Saturating byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_eof) begin
            r_pos <= '0;
        end else if (w_byte && (r_pos != POS_MAX)) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    // Verdict
    always_comb begin
        w_inc = 1'b0;
        w_exc = 1'b0;
        w_any = 1'b0;
        for (int s = 0; s < NUM_PATTERNS; s++) begin
            if (w_stat[s].enabled) begin
                if (w_stat[s].negated) begin
                    w_exc = w_exc | w_stat[s].hit;
                end else begin
                    w_any = 1'b1;
                    w_inc = w_inc | w_stat[s].hit;
                end
            end
        end
        w_sok = (r_pos >= r_min) && (r_pos <= r_max);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_eof) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eof) begin
            r_acc  <= w_sok && !w_exc && (!w_any || w_inc);
            r_sok  <= w_sok;
            r_inc  <= w_inc;
            r_exc  <= w_exc;
            r_size <= r_pos;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.accepted    = r_acc;
    assign o_out.size_ok     = r_sok;
    assign o_out.include_hit = r_inc;
    assign o_out.exclude_hit = r_exc;
    assign o_out.file_size   = r_size;
endmodule

>>> rtl/sfm_checker.sv
module sfm_checker import sfm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_accepted,
    input logic             i_size_ok,
    input logic             i_exclude_hit,
    input logic [POS_W-1:0] i_file_size
);
    // A waiting verdict holds its size
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_file_size))
        else $error("verdict dropped or changed while stalled");

    // Accept needs size in range
    a_acc_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> i_size_ok)
        else $error("accepted without size_ok");

    // Accept never with an exclusion hit
    a_acc_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> !i_exclude_hit)
        else $error("accepted with exclude hit");

    // Input is open whenever no verdict waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
endmodule

bind file_content_signature_filter_top sfm_checker u_sfm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_accepted   (o_out.accepted),
    .i_size_ok    (o_out.size_ok),
    .i_exclude_hit(o_out.exclude_hit),
    .i_file_size  (o_out.file_size)
);

>>> tb/sv/sfm_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// pattern table and per-file state, and checks every verdict in order.
module sfm_verdict_checker import sfm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data,
    sfm_in_if                    in_ch,
    sfm_out_if                   out_ch,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int NPAT = NUM_PATTERNS_DEF;
    localparam int PLEN = MAX_PAT_LEN_DEF;

    typedef struct packed {
        logic             accepted;
        logic             size_ok;
        logic             include_hit;
        logic             exclude_hit;
        logic [POS_W-1:0] file_size;
    } t_verdict;

    // Shadow table and per-file state
    logic [BYTE_W-1:0] pat_bytes [NPAT][PLEN];
    logic [PLEN_W-1:0] pat_len   [NPAT];
    logic              pat_anch  [NPAT];
    logic [POS_W-1:0]  pat_start [NPAT];
    logic              pat_neg   [NPAT];
    logic              pat_en    [NPAT];
    logic [BYTE_W-1:0] window    [PLEN];
    logic [POS_W-1:0]  byte_pos;
    logic [NPAT-1:0]   hits;
    logic [POS_W-1:0]  min_size;
    logic [POS_W-1:0]  max_size;

    t_verdict verdict_q[$];
    int       errors;

    assign o_errors  = errors;
    assign o_pending = verdict_q.size();

    initial errors = 0;

    function automatic void clear_file();
        for (int i = 0; i < PLEN; i++) window[i] = '0;
        byte_pos = '0;
        hits     = '0;
    endfunction

    // Does slot s end a match at file offset ofs (window already shifted)
    function automatic bit slot_matches(int s, logic [POS_W-1:0] ofs);
        int n;
        n = pat_len[s];
        if (n == 0 || n > PLEN) return 0;
        if (64'(ofs) + 64'd1 < 64'(n)) return 0;
        if (pat_anch[s] && (64'(pat_start[s]) + 64'(n) - 64'd1 != 64'(ofs))) return 0;
        for (int i = 0; i < n; i++)
            if (pat_bytes[s][i] != window[n-1-i]) return 0;
        return 1;
    endfunction

    function automatic void take_item();
        t_op      op;
        int       s;
        bit       inc, exc, any_inc, ok;
        t_verdict v;
        op = t_op'(in_ch.operation);
        s  = in_ch.slot;
        case (op)
            OP_LOAD_BYTE: pat_bytes[s][in_ch.byte_index] = in_ch.byte_value;
            OP_LOAD_ATTR: begin
                ok           = in_ch.pattern_length >= 1 && in_ch.pattern_length <= PLEN;
                pat_len[s]   = in_ch.pattern_length;
                pat_anch[s]  = in_ch.anchored;
                pat_start[s] = in_ch.anchor_offset;
                pat_neg[s]   = in_ch.negate;
                pat_en[s]    = ok ? in_ch.enable : 1'b0;
                hits[s]      = 1'b0;
            end
            OP_FILE_BYTE: begin
                for (int i = PLEN - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = in_ch.byte_value;
                for (int k = 0; k < NPAT; k++)
                    if (pat_en[k] && slot_matches(k, byte_pos)) hits[k] = 1'b1;
                if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
            end
            default: begin
                inc = 0; exc = 0; any_inc = 0;
                for (int k = 0; k < NPAT; k++) begin
                    if (pat_en[k]) begin
                        if (pat_neg[k]) begin
                            if (hits[k]) exc = 1;
                        end else begin
                            any_inc = 1;
                            if (hits[k]) inc = 1;
                        end
                    end
                end
                v.size_ok     = byte_pos >= min_size && byte_pos <= max_size;
                v.include_hit = inc;
                v.exclude_hit = exc;
                v.accepted    = v.size_ok && !exc && (!any_inc || inc);
                v.file_size   = byte_pos;
                verdict_q.insert(verdict_q.size(), v);
                clear_file();
            end
        endcase
    endfunction

    function automatic void check_verdict();
        t_verdict got, want;
        got = {out_ch.accepted, out_ch.size_ok, out_ch.include_hit,
               out_ch.exclude_hit, out_ch.file_size};
        if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict %h", $time, got);
            errors++;
            return;
        end
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted) begin
            $display("%0t: accepted exp %b got %b", $time, want.accepted, got.accepted);
            errors++;
        end
        if (got.size_ok !== want.size_ok) begin
            $display("%0t: size_ok exp %b got %b", $time, want.size_ok, got.size_ok);
            errors++;
        end
        if (got.include_hit !== want.include_hit) begin
            $display("%0t: include_hit exp %b got %b", $time, want.include_hit,
                     got.include_hit);
            errors++;
        end
        if (got.exclude_hit !== want.exclude_hit) begin
            $display("%0t: exclude_hit exp %b got %b", $time, want.exclude_hit,
                     got.exclude_hit);
            errors++;
        end
        if (got.file_size !== want.file_size) begin
            $display("%0t: file_size exp %0d got %0d", $time, want.file_size,
                     got.file_size);
            errors++;
        end
    endfunction

    // Sample at the edge: outputs compared before the new item is applied
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPAT; k++) begin
                pat_en[k]  = 1'b0;
                pat_len[k] = '0;
            end
            clear_file();
            min_size = '0;
            max_size = POS_MAX;
            verdict_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) check_verdict();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_SIZE) min_size = i_cfg_data;
                else if (i_cfg_idx == CFG_MAX_SIZE) max_size = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) take_item();
        end
    end

endmodule

>>> tb/sv/tb_file_content_signature_filter_top.sv
`timescale 1ns / 1ps

module tb_file_content_signature_filter_top;
    import sfm_pkg::*;

    localparam int NPAT = NUM_PATTERNS_DEF;
    localparam int PLEN = MAX_PAT_LEN_DEF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [POS_W-1:0]     i_cfg_data;
    int                   errors;
    int                   pending;

    sfm_in_if  in_ch ();
    sfm_out_if out_ch ();

    file_content_signature_filter_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sfm_verdict_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Stimulus-side copy of what was loaded, used to plant real matches
    logic [BYTE_W-1:0] sh_bytes [NPAT][PLEN];
    int                sh_len   [NPAT];
    int                items_sent;
    int                burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver stall pattern: ready follows a randomly chosen mode
    int rcv_cyc;
    int rcv_mode;
    always @(posedge i_clk) begin
        rcv_cyc <= rcv_cyc + 1;
        if (rcv_cyc % 200 == 0) rcv_mode <= $urandom_range(0, 3);
        case (rcv_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ($urandom_range(0, 9) < 5);
        endcase
    end

    // Drive one item and hold it until taken; bursts usually separated by gaps
    task automatic send(t_op op, int slot, int bidx, int bval, int plen, bit anch,
                        logic [POS_W-1:0] aoff, bit neg, bit en);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.slot           <= SLOT_W'(slot);
        in_ch.byte_index     <= BIDX_W'(bidx);
        in_ch.byte_value     <= BYTE_W'(bval);
        in_ch.pattern_length <= PLEN_W'(plen);
        in_ch.anchored       <= anch;
        in_ch.anchor_offset  <= aoff;
        in_ch.negate         <= neg;
        in_ch.enable         <= en;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [POS_W-1:0] rnd40();
        return POS_W'({$urandom, $urandom});
    endfunction

    task automatic load_byte(int s, int i, int v);
        send(OP_LOAD_BYTE, s, i, v, $urandom, 1'($urandom), rnd40(), 1'($urandom),
             1'($urandom));
        sh_bytes[s][i] = BYTE_W'(v);
    endtask

    task automatic load_attr(int s, int n, bit anch, logic [POS_W-1:0] aoff, bit neg, bit en);
        send(OP_LOAD_ATTR, s, $urandom, $urandom, n, anch, aoff, neg, en);
        sh_len[s] = n;
    endtask

    task automatic file_byte(int v);
        send(OP_FILE_BYTE, $urandom, $urandom, v, $urandom, 1'($urandom), rnd40(),
             1'($urandom), 1'($urandom));
    endtask

    task automatic end_file();
        send(OP_EOF, $urandom, $urandom, $urandom, $urandom, 1'($urandom), rnd40(),
             1'($urandom), 1'($urandom));
    endtask

    // Idle the input and let every verdict drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write, after which the enable goes low
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random attributes, mostly usable, sometimes a bad length
    task automatic rand_attr(int s);
        int n;
        logic [POS_W-1:0] aoff;
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        aoff = ($urandom_range(0, 7) == 0) ? rnd40() : POS_W'($urandom_range(0, 30));
        load_attr(s, n, $urandom_range(0, 2) == 0, aoff, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 5) != 0);
    endtask

    // One file: mostly planted patterns with noise, sometimes reloads mid-file
    task automatic rand_file();
        int target;
        int n;
        int s;
        target = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 35);
        n = 0;
        if ($urandom_range(0, 2) == 0) rand_attr($urandom_range(0, NPAT - 1));
        while (n < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    s = $urandom_range(0, NPAT - 1);
                    if (sh_len[s] >= 1 && sh_len[s] <= PLEN) begin
                        for (int i = 0; i < sh_len[s]; i++) file_byte(sh_bytes[s][i]);
                        n += sh_len[s];
                    end
                end
                4: rand_attr($urandom_range(0, NPAT - 1));
                5: load_byte($urandom_range(0, NPAT - 1), $urandom_range(0, PLEN - 1),
                             $urandom_range(0, 255));
                6: begin
                    file_byte($urandom_range(0, 3));
                    n++;
                end
                default: begin
                    file_byte($urandom_range(0, 255));
                    n++;
                end
            endcase
        end
        end_file();
    endtask

    logic [POS_W-1:0] lo_set [7];
    logic [POS_W-1:0] hi_set [7];

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_MIN_SIZE;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_LOAD_BYTE;
        in_ch.slot           = '0;
        in_ch.byte_index     = '0;
        in_ch.byte_value     = '0;
        in_ch.pattern_length = '0;
        in_ch.anchored       = 1'b0;
        in_ch.anchor_offset  = '0;
        in_ch.negate         = 1'b0;
        in_ch.enable         = 1'b0;
        out_ch.ready         = 1'b0;
        rcv_cyc              = 0;
        rcv_mode             = 0;
        items_sent           = 0;
        burst_left           = 0;
        for (int s = 0; s < NPAT; s++) sh_len[s] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, empty file
        end_file();
        // Include pattern 00 FF anywhere; exclude AA anchored at offset 3
        load_byte(0, 0, 8'h00);
        load_byte(0, 1, 8'hFF);
        load_attr(0, 2, 1'b0, '0, 1'b0, 1'b1);
        load_byte(1, 0, 8'hAA);
        load_attr(1, 1, 1'b1, 40'd3, 1'b1, 1'b1);
        // Bad lengths disable the slot even with enable set
        load_attr(2, 0, 1'b1, POS_MAX, 1'b1, 1'b1);
        load_attr(3, 17, 1'b0, POS_MAX, 1'b0, 1'b1);
        // No inclusion hit
        file_byte(8'hFF);
        end_file();
        // Inclusion hit, AA off its anchor
        file_byte(8'hAA);
        file_byte(8'h00);
        file_byte(8'hFF);
        end_file();
        // Exclusion hit at the anchor
        file_byte(8'h00);
        file_byte(8'hFF);
        file_byte(8'h11);
        file_byte(8'hAA);
        end_file();
        // Reload clears a hit mid-file
        file_byte(8'h00);
        file_byte(8'hFF);
        load_attr(0, 2, 1'b0, POS_MAX, 1'b0, 1'b1);
        end_file();
        wait_idle();

        // Fill every pattern byte so nothing unwritten is ever compared
        for (int s = 0; s < NPAT; s++)
            for (int i = 0; i < PLEN; i++)
                load_byte(s, i, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 255));
        for (int s = 0; s < NPAT; s++) rand_attr(s);

        // Size bounds per phase: full range, zero, top only, inverted, windows
        lo_set = '{40'd0, 40'd0, POS_MAX, 40'd20, 40'd5, 40'd0, POS_MAX};
        hi_set = '{POS_MAX, 40'd0, POS_MAX, 40'd10, 40'd30, 40'd0, 40'd0};
        lo_set[5] = POS_W'($urandom_range(0, 20));
        hi_set[5] = lo_set[5] + POS_W'($urandom_range(0, 40));
        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            write_reg(CFG_MIN_SIZE, lo_set[ph]);
            write_reg(CFG_MAX_SIZE, hi_set[ph]);
            while (items_sent < 180 + (ph + 1) * 220) rand_file();
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sfm_pkg.sv
rtl/sfm_in_if.sv
rtl/sfm_out_if.sv
rtl/sfm_cell.sv
rtl/sfm_slot.sv
rtl/file_content_signature_filter_top.sv
rtl/sfm_checker.sv
tb/sv/sfm_verdict_checker.sv
tb/sv/tb_file_content_signature_filter_top.sv
